// File: rtl/relay_dedupe_filter_fnv1a_assert.svh
// Assertion macros shared by the duplicate filter modules.
// Each macro samples on the rising clock edge and is quiet while reset is asserted.
`ifndef RELAY_DEDUPE_FILTER_FNV1A_ASSERT_SVH
`define RELAY_DEDUPE_FILTER_FNV1A_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define RDF_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("relay dedupe filter: same-cycle check failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define RDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("relay dedupe filter: next-cycle check failed");

`endif

// File: rtl/rdf_pkg.sv
`default_nettype none

package rdf_pkg;

	localparam int unsigned CACHE_DEPTH = 16;
	localparam int unsigned CACHE_IDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;

	localparam logic [7:0] MAX_HOPS_RESET = 8'd3;

	localparam logic OP_KEY    = 1'b0;
	localparam logic OP_COMMIT = 1'b1;

	localparam logic [1:0] VERDICT_RELAY = 2'd0;
	localparam logic [1:0] VERDICT_OWN   = 2'd1;
	localparam logic [1:0] VERDICT_DUP   = 2'd2;
	localparam logic [1:0] VERDICT_HOPS  = 2'd3;

	// One entry of the queue between the front and the back.
	typedef struct packed {
		logic        is_commit;
		logic [31:0] hash;
		logic [7:0]  hop_count;
		logic        from_self;
	} rdf_entry_t;

	// One FNV-1a round: xor the byte in, then multiply by the prime 0x01000193.
	// The constant multiply is written as a sum of shifted copies.
	function automatic logic [31:0] fnv1a_step(input logic [31:0] hash, input logic [7:0] data);
		logic [31:0] x;
		begin
			x = hash ^ {24'd0, data};
			return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
		end
	endfunction

endpackage

`default_nettype wire

// File: rtl/rdf_front.sv
`default_nettype none

// Front part: takes input transactions, folds key bytes into the running hash
// and hands completed keys and commits to the queue.
module rdf_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               op,
	input  wire logic [7:0]         key_byte,
	input  wire logic               key_last,
	input  wire logic [7:0]         hop_count,
	input  wire logic               from_self,
	input  wire logic               q_full,
	output logic                    q_push,
	output rdf_pkg::rdf_entry_t     q_push_data
);

	logic [31:0] running_hash_q;
	logic [31:0] next_hash;
	logic        accept;

	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign next_hash = rdf_pkg::fnv1a_step(running_hash_q, key_byte);

	// Only commits and final key bytes produce work for the back part.
	assign q_push = accept && ((op == rdf_pkg::OP_COMMIT) || key_last);

	always_comb begin
		q_push_data.is_commit = (op == rdf_pkg::OP_COMMIT);
		q_push_data.hash      = next_hash;
		q_push_data.hop_count = hop_count;
		q_push_data.from_self = from_self;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_hash_q <= rdf_pkg::FNV_BASIS;
		end else if (accept && (op == rdf_pkg::OP_KEY)) begin
			if (key_last) begin
				running_hash_q <= rdf_pkg::FNV_BASIS;
			end else begin
				running_hash_q <= next_hash;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/rdf_queue.sv
`default_nettype none

`include "relay_dedupe_filter_fnv1a_assert.svh"

// Short in-order queue that decouples the front from the back.
module rdf_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire rdf_pkg::rdf_entry_t  push_data,
	output logic                      full,
	input  wire logic                 pop,
	output rdf_pkg::rdf_entry_t       pop_data,
	output logic                      empty
);

	rdf_pkg::rdf_entry_t                 slots_q [rdf_pkg::QUEUE_DEPTH];
	logic [rdf_pkg::QUEUE_IDX_W-1:0]     wr_ptr_q;
	logic [rdf_pkg::QUEUE_IDX_W-1:0]     rd_ptr_q;
	logic [rdf_pkg::QUEUE_CNT_W-1:0]     count_q;

	localparam logic [rdf_pkg::QUEUE_IDX_W-1:0] LAST_IDX =
		rdf_pkg::QUEUE_IDX_W'(rdf_pkg::QUEUE_DEPTH - 1);
	localparam logic [rdf_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
		rdf_pkg::QUEUE_CNT_W'(rdf_pkg::QUEUE_DEPTH);

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign pop_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`RDF_ASSERT_IMPLIES(a_no_push_when_full, clk, arst_n, push, !full)
	`RDF_ASSERT_IMPLIES(a_no_pop_when_empty, clk, arst_n, pop, !empty)
	`RDF_ASSERT_IMPLIES(a_count_in_range, clk, arst_n, 1'b1, count_q <= FULL_CNT)

endmodule

`default_nettype wire

// File: rtl/rdf_back.sv
`default_nettype none

`include "relay_dedupe_filter_fnv1a_assert.svh"

// Back part: holds the ring of recent hashes, carries out commits and gives
// verdicts into the output register.
module rdf_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [7:0]          cfg_wdata,
	input  wire logic                q_empty,
	input  wire rdf_pkg::rdf_entry_t q_data,
	output logic                     q_pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [1:0]               verdict,
	output logic [7:0]               new_hops,
	output logic [31:0]              key_hash
);

	localparam logic [rdf_pkg::CACHE_IDX_W-1:0] LAST_SLOT =
		rdf_pkg::CACHE_IDX_W'(rdf_pkg::CACHE_DEPTH - 1);

	logic [31:0]                     ring_q [rdf_pkg::CACHE_DEPTH];
	logic [rdf_pkg::CACHE_IDX_W-1:0] wr_ptr_q;
	logic [31:0]                     held_hash_q;
	logic [7:0]                      max_hops_q;
	logic                            out_valid_q;
	logic [1:0]                      verdict_q;
	logic [7:0]                      new_hops_q;
	logic [31:0]                     key_hash_q;

	logic        hit;
	logic        commit_pop;
	logic        verdict_pop;
	logic [1:0]  verdict_d;
	logic [7:0]  new_hops_d;

	// A commit needs no output slot, so it leaves the queue whenever present.
	assign q_pop       = !q_empty && (q_data.is_commit || !out_valid_q || out_ready);
	assign commit_pop  = q_pop && q_data.is_commit;
	assign verdict_pop = q_pop && !q_data.is_commit;

	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < rdf_pkg::CACHE_DEPTH; i++) begin
			if (ring_q[i] == q_data.hash) begin
				hit = 1'b1;
			end
		end
	end

	always_comb begin
		new_hops_d = 8'd0;
		if (q_data.from_self) begin
			verdict_d = rdf_pkg::VERDICT_OWN;
		end else if (hit) begin
			verdict_d = rdf_pkg::VERDICT_DUP;
		end else if (q_data.hop_count >= max_hops_q) begin
			verdict_d = rdf_pkg::VERDICT_HOPS;
		end else begin
			verdict_d  = rdf_pkg::VERDICT_RELAY;
			new_hops_d = q_data.hop_count + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rdf_pkg::CACHE_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
			wr_ptr_q    <= '0;
			held_hash_q <= '0;
			max_hops_q  <= rdf_pkg::MAX_HOPS_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_hops_q <= cfg_wdata;
			end
			if (commit_pop) begin
				ring_q[wr_ptr_q] <= held_hash_q;
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (verdict_pop) begin
				held_hash_q <= q_data.hash;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (verdict_pop) begin
			verdict_q  <= verdict_d;
			new_hops_q <= new_hops_d;
			key_hash_q <= q_data.hash;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;
	assign new_hops  = new_hops_q;
	assign key_hash  = key_hash_q;

	`RDF_ASSERT_IMPLIES(a_relay_hops_nonzero, clk, arst_n,
		out_valid_q && (verdict_q == rdf_pkg::VERDICT_RELAY), new_hops_q != 8'd0)
	`RDF_ASSERT_NEXT(a_ptr_moves_on_commit_only, clk, arst_n, !commit_pop, $stable(wr_ptr_q))
	`RDF_ASSERT_IMPLIES(a_no_overwrite_pending, clk, arst_n,
		out_valid_q && !out_ready, !verdict_pop)

endmodule

`default_nettype wire

// File: rtl/relay_dedupe_filter_fnv1a.sv
// Relay duplicate filter with a 32-bit FNV-1a key hash.
// Input channel (in_valid/in_ready): each transaction is either a key byte
// (op = 0) or a commit (op = 1). Key bytes fold into the running hash; the
// byte with key_last set also carries hop_count and from_self and yields one
// output transaction. A commit writes the last completed hash into the ring
// of recent hashes and yields no output.
// Output channel (out_valid/out_ready): verdict, new_hops and key_hash.
// Configuration: cfg_we writes cfg_wdata into max_hops in the same edge.
// The final key byte is written into the queue when it is taken; out_valid
// rises when the back pops it from there into the output register.
// Throughput: one input transaction per cycle, set by the combinational FNV
// round in the front and the one-entry-per-cycle queue drain in the back.
// When the receiver stalls, the result waits in the output register, the
// four-entry queue keeps absorbing work, and in_ready drops only once the
// queue is full. A commit at the head of the queue still drains during a
// stall; one queued behind a waiting verdict waits with it.
// Reset: max_hops returns to 3, the running hash to the offset basis, and the
// held hash, ring entries and write pointer to zero, all at once, so the
// block takes transactions as soon as reset is released.
`default_nettype none

module relay_dedupe_filter_fnv1a (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        op,
	input  wire logic [7:0]  key_byte,
	input  wire logic        key_last,
	input  wire logic [7:0]  hop_count,
	input  wire logic        from_self,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       verdict,
	output logic [7:0]       new_hops,
	output logic [31:0]      key_hash
);

	// Queue handshake between the front and the back parts.
	logic                 q_push;
	logic                 q_full;
	logic                 q_pop;
	logic                 q_empty;
	rdf_pkg::rdf_entry_t  q_push_data;
	rdf_pkg::rdf_entry_t  q_pop_data;

	// The front hashes key bytes and classifies each transaction.
	rdf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.key_byte    (key_byte),
		.key_last    (key_last),
		.hop_count   (hop_count),
		.from_self   (from_self),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_push_data (q_push_data)
	);

	// Completed keys and commits keep their order through the queue, so each
	// verdict sees exactly the commits that came before it.
	rdf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.empty     (q_empty)
	);

	// The back looks the hash up in the ring and registers the verdict.
	rdf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_empty   (q_empty),
		.q_data    (q_pop_data),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.verdict   (verdict),
		.new_hops  (new_hops),
		.key_hash  (key_hash)
	);

endmodule

`default_nettype wire

// File: sim/relay_dedupe_filter_fnv1a_checker.sv
`timescale 1ns / 1ps

module relay_dedupe_filter_fnv1a_checker
	import rdf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        op,
	input  logic [7:0]  key_byte,
	input  logic        key_last,
	input  logic [7:0]  hop_count,
	input  logic        from_self,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  verdict,
	input  logic [7:0]  new_hops,
	input  logic [31:0] key_hash,
	output int          fail_count,
	output int          outstanding
);

	localparam logic [31:0] FNV_PRIME = 32'd16777619;

	typedef struct packed {
		logic [1:0]  verdict;
		logic [7:0]  new_hops;
		logic [31:0] key_hash;
	} verdict_t;

	verdict_t    pending_verdicts[$];
	logic [7:0]  hop_limit;
	logic [31:0] partial_hash;
	logic [31:0] completed_hash;
	logic [31:0] recent[CACHE_DEPTH];
	int unsigned ring_slot;

	function automatic logic [31:0] fnv_fold(input logic [31:0] h, input logic [7:0] b);
		return (h ^ {24'd0, b}) * FNV_PRIME;
	endfunction

	function automatic logic seen_recently(input logic [31:0] h);
		for (int i = 0; i < CACHE_DEPTH; i++)
			if (recent[i] == h)
				return 1'b1;
		return 1'b0;
	endfunction

	// Applies one accepted input transaction to the shadow state and queues
	// the verdict it should produce, if any.
	task automatic absorb_transaction();
		verdict_t    want;
		logic [31:0] h;
		if (op == OP_COMMIT) begin
			recent[ring_slot] = completed_hash;
			ring_slot = (ring_slot + 1) % CACHE_DEPTH;
			return;
		end
		h = fnv_fold(partial_hash, key_byte);
		if (!key_last) begin
			partial_hash = h;
			return;
		end
		partial_hash = FNV_BASIS;
		completed_hash = h;
		want.key_hash = h;
		want.new_hops = 8'd0;
		if (from_self) begin
			want.verdict = VERDICT_OWN;
		end else if (seen_recently(h)) begin
			want.verdict = VERDICT_DUP;
		end else if (hop_count >= hop_limit) begin
			want.verdict = VERDICT_HOPS;
		end else begin
			want.verdict = VERDICT_RELAY;
			want.new_hops = hop_count + 8'd1;
		end
		pending_verdicts.push_back(want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			hop_limit = MAX_HOPS_RESET;
			partial_hash = FNV_BASIS;
			completed_hash = 32'd0;
			for (int i = 0; i < CACHE_DEPTH; i++)
				recent[i] = 32'd0;
			ring_slot = 0;
			pending_verdicts.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (cfg_we)
				hop_limit = cfg_wdata;
			if (out_valid && out_ready) begin
				if (pending_verdicts.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual verdict %0d hops %0d hash %h",
						$time, verdict, new_hops, key_hash);
					fail_count++;
				end else begin
					want = pending_verdicts.pop_front();
					if (verdict !== want.verdict) begin
						$display("%0t: verdict mismatch, expected %0d, actual %0d",
							$time, want.verdict, verdict);
						fail_count++;
					end
					if (new_hops !== want.new_hops) begin
						$display("%0t: new_hops mismatch, expected %0d, actual %0d",
							$time, want.new_hops, new_hops);
						fail_count++;
					end
					if (key_hash !== want.key_hash) begin
						$display("%0t: key_hash mismatch, expected %h, actual %h",
							$time, want.key_hash, key_hash);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				absorb_transaction();
			outstanding = pending_verdicts.size();
		end
	end

endmodule

// File: sim/tb_relay_dedupe_filter_fnv1a.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the relay duplicate filter. The checker instance
// beside the block shadows the hash, the ring of recent hashes and the hop
// limit, and compares every output transaction against its own prediction.
// This module only drives the clock, reset, channels and configuration register.
module tb_relay_dedupe_filter_fnv1a;
	import rdf_pkg::*;

	// Items per random traffic phase and per final phase without idling.
	localparam int PHASE_ITEMS   = 205;
	localparam int TAIL_ITEMS    = 200;
	// The receiver stops once for this many cycles, far longer than the
	// output register plus the four-entry queue can absorb.
	localparam int LONG_HOLD     = 80;
	localparam int HOLD_AT_ITEM  = 100;
	// Commits can still sit in the queue after the last result has come out,
	// so the bench lets them drain for this long before a write.
	localparam int SETTLE_CYCLES = 12;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int POOL_SIZE     = 8;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic        op;
	logic [7:0]  key_byte;
	logic        key_last;
	logic [7:0]  hop_count;
	logic        from_self;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  verdict;
	logic [7:0]  new_hops;
	logic [31:0] key_hash;

	int fail_count;
	int outstanding;

	// Shared between the sender and the receiver: the receiver watches the
	// transaction count to place its long hold-off, and the final phase
	// switches idling off on both sides.
	int   sent_count     = 0;
	bit   quiet_tail     = 1'b0;
	bit   long_hold_done = 1'b0;
	logic [7:0] cur_max_hops = MAX_HOPS_RESET;

	// Recently used keys, replayed so that the ring sees real duplicates.
	logic [7:0] key_pool [0:POOL_SIZE-1][0:7];
	int         key_len  [0:POOL_SIZE-1];
	int         pool_fill = 0;
	int         pool_next = 0;

	relay_dedupe_filter_fnv1a DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.key_byte  (key_byte),
		.key_last  (key_last),
		.hop_count (hop_count),
		.from_self (from_self),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.verdict   (verdict),
		.new_hops  (new_hops),
		.key_hash  (key_hash)
	);

	relay_dedupe_filter_fnv1a_checker checker_inst (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.key_byte    (key_byte),
		.key_last    (key_last),
		.hop_count   (hop_count),
		.from_self   (from_self),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.verdict     (verdict),
		.new_hops    (new_hops),
		.key_hash    (key_hash),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A hung handshake or a lost result ends the run here.
	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Offers one transaction on the input channel. Called at a falling edge;
	// it returns at the falling edge after the transaction was taken. An
	// optional idle burst is inserted before valid is raised, so valid never
	// drops while an offer is pending.
	task automatic send_item(input logic o, input logic [7:0] b, input logic l,
			input logic [7:0] h, input logic s);
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid  <= 1'b1;
		op        <= o;
		key_byte  <= b;
		key_last  <= l;
		hop_count <= h;
		from_self <= s;
		do @(posedge clk); while (!in_ready);
		sent_count++;
		@(negedge clk);
	endtask

	// A commit ignores every field but op, so the rest carries random noise.
	task automatic send_commit();
		send_item(OP_COMMIT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	// Streams a whole key. Hop count and origin flag only matter on the last
	// byte; the earlier bytes carry random values there.
	task automatic send_packet(input logic [7:0] key [0:7], input int len,
			input logic [7:0] hops, input logic self);
		for (int i = 0; i < len - 1; i++)
			send_item(OP_KEY, key[i], 1'b0, 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)));
		send_item(OP_KEY, key[len-1], 1'b1, hops, self);
	endtask

	// Hop counts cluster around the current limit so that both sides of the
	// comparison are hit often; the rest spread over the whole byte.
	function automatic logic [7:0] pick_hops();
		int h;
		case ($urandom_range(0, 3))
			0: h = int'(cur_max_hops) - 1;
			1: h = int'(cur_max_hops);
			2: h = int'(cur_max_hops) + 1;
			default: h = $urandom_range(0, 255);
		endcase
		if (h < 0)
			h = 0;
		if (h > 255)
			h = 255;
		return h[7:0];
	endfunction

	// Mostly well-formed packets, each often followed by a commit as after a
	// successful transmit. A small share is stray commits and abandoned key
	// prefixes, which simply run on into the next key's hash.
	task automatic run_traffic(input int n);
		logic [7:0] key [0:7];
		int         len;
		int         stop;
		int         slot;
		int         r;
		stop = sent_count + n;
		while (sent_count < stop) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				send_commit();
			end else if (r < 12) begin
				repeat ($urandom_range(1, 3))
					send_item(OP_KEY, 8'($urandom_range(0, 255)), 1'b0,
						8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else begin
				if (pool_fill > 0 && $urandom_range(0, 99) < 45) begin
					slot = $urandom_range(0, pool_fill - 1);
					key = key_pool[slot];
					len = key_len[slot];
				end else begin
					len = $urandom_range(1, 6);
					for (int i = 0; i < 8; i++)
						key[i] = 8'($urandom_range(0, 255));
					key_pool[pool_next] = key;
					key_len[pool_next] = len;
					pool_next = (pool_next + 1) % POOL_SIZE;
					if (pool_fill < POOL_SIZE)
						pool_fill++;
				end
				send_packet(key, len, pick_hops(), $urandom_range(0, 9) == 0);
				if ($urandom_range(0, 99) < 60)
					send_commit();
			end
		end
	endtask

	// The register is written only with the block idle: every predicted
	// result has come out, and a settling wait lets trailing commits leave
	// the queue.
	task automatic set_max_hops(input logic [7:0] v);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_max_hops = v;
	endtask

	// Receiver: random ready bursts, one long hold-off early in the run while
	// the sender keeps offering, and ready held high during the final phase.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!long_hold_done && sent_count >= HOLD_AT_ITEM) begin
				long_hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
	end

	initial begin
		logic [7:0] limits [0:4];
		int         drain_wait;
		cfg_we    = 1'b0;
		cfg_wdata = 8'd0;
		in_valid  = 1'b0;
		op        = OP_KEY;
		key_byte  = 8'd0;
		key_last  = 1'b0;
		hop_count = 8'd0;
		from_self = 1'b0;
		arst_n    = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, with the limit still at its reset value of three.
		// This four-byte key hashes to zero, which matches the cleared ring
		// entries, so it must come back as a duplicate.
		send_item(OP_KEY, 8'hcc, 1'b0, 8'hff, 1'b1);
		send_item(OP_KEY, 8'h24, 1'b0, 8'h00, 1'b0);
		send_item(OP_KEY, 8'h31, 1'b0, 8'h55, 1'b1);
		send_item(OP_KEY, 8'hc4, 1'b1, 8'h00, 1'b0);
		send_item(OP_COMMIT, 8'h00, 1'b0, 8'h00, 1'b0);
		// A one-byte key with hop count one below the limit relays with the count raised by one.
		send_item(OP_KEY, 8'hff, 1'b1, 8'd2, 1'b0);
		send_item(OP_COMMIT, 8'hff, 1'b1, 8'hff, 1'b1);
		// The same key again is now a duplicate, unless it is our own.
		send_item(OP_KEY, 8'hff, 1'b1, 8'd0, 1'b0);
		send_item(OP_KEY, 8'hff, 1'b1, 8'd0, 1'b1);
		send_item(OP_KEY, 8'hff, 1'b1, 8'd255, 1'b1);
		// Hop count equal to the limit and at the top of its range.
		send_item(OP_KEY, 8'h00, 1'b1, 8'd3, 1'b0);
		send_item(OP_KEY, 8'h00, 1'b1, 8'd255, 1'b0);
		// A commit in the middle of a key must not disturb its running hash.
		send_item(OP_KEY, 8'h5a, 1'b0, 8'h00, 1'b0);
		send_item(OP_COMMIT, 8'hff, 1'b1, 8'hff, 1'b1);
		send_item(OP_KEY, 8'ha5, 1'b1, 8'd1, 1'b0);
		// Repeated commits of one hash, then that key once more.
		send_item(OP_COMMIT, 8'h00, 1'b0, 8'h00, 1'b0);
		send_item(OP_COMMIT, 8'h81, 1'b1, 8'h7e, 1'b0);
		send_item(OP_KEY, 8'h5a, 1'b0, 8'h00, 1'b0);
		send_item(OP_KEY, 8'ha5, 1'b1, 8'd1, 1'b0);
		run_traffic(PHASE_ITEMS);

		// Random phases under several limits: zero stops every relay, the
		// top value lets a count of 254 relay as 255.
		limits = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(0, 255)), 8'($urandom_range(2, 8))};
		foreach (limits[i]) begin
			set_max_hops(limits[i]);
			run_traffic(PHASE_ITEMS);
		end

		// Final phase: back to a small limit, and no idling on either side.
		set_max_hops(MAX_HOPS_RESET);
		quiet_tail = 1'b1;
		run_traffic(TAIL_ITEMS);

		in_valid <= 1'b0;
		drain_wait = 0;
		while (outstanding != 0 && drain_wait < DRAIN_LIMIT) begin
			@(negedge clk);
			drain_wait++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (outstanding != 0)
			$display("%0t: %0d expected results never arrived", $time, outstanding);
		if (fail_count == 0 && outstanding == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
